// ===== hdl/psmd_pkg.sv =====
`timescale 1ns / 1ps

package psmd_pkg;

	// Default time stamp width
	localparam int TIME_BITS_DEF = 32;

	// Field and register widths
	localparam int OP_W     = 4;
	localparam int MV_W     = 16;
	localparam int MODE_W   = 2;
	localparam int DUTY_W   = 7;
	localparam int PULSE_W  = 8;
	localparam int PERIOD_W = 20;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int NOW_W    = 32;

	// Duty numerator (mV * 100) and pump interval widths
	localparam int NUM_W  = MV_W + 7;
	localparam int K400_W = 13;
	localparam int INTV_W = K400_W + PULSE_W;

	// Restoring division steps after the saturation check
	localparam int DIV_STEPS = DUTY_W;
	localparam int CNT_W     = 3;

	localparam logic [DUTY_W-1:0] DUTY_MAX    = 7'h7f;
	localparam logic [6:0]        PCT_SCALE   = 7'd100;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
	localparam logic [OP_W-1:0] OP_OPEN_SWING = 4'd1;
	localparam logic [OP_W-1:0] OP_OPEN_PUMP  = 4'd2;
	localparam logic [OP_W-1:0] OP_OPEN_BOTH  = 4'd3;
	localparam logic [OP_W-1:0] OP_STOP_SWING = 4'd4;
	localparam logic [OP_W-1:0] OP_STOP_PUMP  = 4'd5;
	localparam logic [OP_W-1:0] OP_STOP_BOTH  = 4'd6;
	localparam logic [OP_W-1:0] OP_MODE_SWING = 4'd7;
	localparam logic [OP_W-1:0] OP_MODE_PUMP  = 4'd8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SWING_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWING_FULL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH    = 2'd3;

	// Configuration reset values
	localparam logic [MV_W-1:0]     SWING_LOW_RST  = 16'd9000;
	localparam logic [MV_W-1:0]     SWING_FULL_RST = 16'd12000;
	localparam logic [PULSE_W-1:0]  MAX_PULSES_RST = 8'd5;
	localparam logic [PERIOD_W-1:0] REFRESH_RST    = 20'd60000;

	// Mode codes
	localparam logic [MODE_W-1:0] SWING_LOW  = 2'd0;
	localparam logic [MODE_W-1:0] SWING_HIGH = 2'd1;
	localparam logic [MODE_W-1:0] PLVL_LOW   = 2'd0;
	localparam logic [MODE_W-1:0] PLVL_MID   = 2'd1;
	localparam logic [MODE_W-1:0] PLVL_HIGH  = 2'd2;

	// Pump interval per pulse: k * 400 ms, k = 15 low, 12 middle, 8 high
	function automatic logic [K400_W-1:0] pump_k400(input logic [MODE_W-1:0] level);
		logic [K400_W-1:0] r;
		case (level)
			PLVL_HIGH: r = 13'd3200;
			PLVL_MID:  r = 13'd4800;
			default:   r = 13'd6000;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/pump_and_swing_motor_drive_top.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    op, now_ms, battery_mv, mode_value
// output    out_valid / out_stall  cmd_byte, swing_on, pump_on, last
// config    cfg_we                 cfg_index, cfg_data
//
// Open-pump and stop items go straight to the emit step; opens with a duty
// calculation first pass the product, check and divider steps, and a tick
// can give two results. One shared subtract/compare unit does the elapsed-time
// subtracts, interval compares and a 7-step restoring divider for the duty.
// in_stall is high while a transaction is being worked on; a result waiting in
// the output register under out_stall holds the sequencer in its emit step.
// arst_n clears the control state and loads the configuration defaults.
`timescale 1ns / 1ps

module pump_and_swing_motor_drive_top
	import psmd_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_W-1:0]       op,
	input  logic [NOW_W-1:0]      now_ms,
	input  logic [MV_W-1:0]       battery_mv,
	input  logic [MODE_W-1:0]     mode_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            cmd_byte,
	output logic                  swing_on,
	output logic                  pump_on,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int ALU_W  = (TIME_BITS > INTV_W) ? TIME_BITS : INTV_W;
	localparam int NOW_NB = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_PSUB = 10'b00_0000_0010,
		S_PCMP = 10'b00_0000_0100,
		S_RSUB = 10'b00_0000_1000,
		S_RCMP = 10'b00_0001_0000,
		S_PROD = 10'b00_0010_0000,
		S_DCHK = 10'b00_0100_0000,
		S_DIV  = 10'b00_1000_0000,
		S_PUPD = 10'b01_0000_0000,
		S_EMIT = 10'b10_0000_0000
	} state_t;

	// Control and architectural state
	state_t                state_q, ret_q;
	logic                  last_q, pfire_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [MV_W-1:0]       swing_low_q, swing_full_q;
	logic [PULSE_W-1:0]    max_pulses_q;
	logic [PERIOD_W-1:0]   refresh_q;
	logic [DUTY_W-1:0]     duty_q;
	logic                  pump_bit_q, swing_sw_q, pump_sw_q;
	logic [PULSE_W-1:0]    pulse_q;
	logic [TIME_BITS-1:0]  last_pump_q, last_refresh_q;
	logic                  mode_changed_q, swing_high_q;
	logic [MODE_W-1:0]     pump_level_q;
	logic                  out_valid_q;

	// Datapath registers
	logic [OP_W-1:0]       op_q;
	logic [TIME_BITS-1:0]  now_q, el_q;
	logic [MV_W-1:0]       batt_q;
	logic [INTV_W-1:0]     interval_q;
	logic [NUM_W-1:0]      num_q;
	logic [MV_W-1:0]       rem_q;
	logic [DUTY_W-1:0]     qsh_q;
	logic [7:0]            cmd_q;
	logic                  swing_on_q, pump_on_q, last_out_q;

	logic                  in_acc, out_free;
	logic [TIME_BITS-1:0]  now_w;
	logic [ALU_W-1:0]      alu_a, alu_b;
	logic [ALU_W:0]        alu_diff;
	logic                  alu_borrow;
	logic [MV_W:0]         div_t;
	logic                  fin_go;
	logic [DUTY_W-1:0]     fin_duty;
	logic [PULSE_W:0]      pulse_nxt;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign now_w     = TIME_BITS'(now_ms[NOW_NB-1:0]);
	assign div_t     = {rem_q, qsh_q[DUTY_W-1]};
	assign pulse_nxt = {1'b0, pulse_q} + 1'b1;

	assign out_valid = out_valid_q;
	assign cmd_byte  = cmd_q;
	assign swing_on  = swing_on_q;
	assign pump_on   = pump_on_q;
	assign last      = last_out_q;

	// Shared subtract / compare unit
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_PSUB: begin
				alu_a = ALU_W'(now_q);
				alu_b = ALU_W'(last_pump_q);
			end
			S_PCMP: begin
				alu_a = ALU_W'(interval_q);
				alu_b = ALU_W'(el_q);
			end
			S_RSUB: begin
				alu_a = ALU_W'(now_q);
				alu_b = ALU_W'(last_refresh_q);
			end
			S_RCMP: begin
				alu_a = ALU_W'(refresh_q);
				alu_b = ALU_W'(el_q);
			end
			S_DCHK: begin
				alu_a = ALU_W'(num_q[NUM_W-1:DUTY_W]);
				alu_b = ALU_W'(batt_q);
			end
			S_DIV: begin
				alu_a = ALU_W'(div_t);
				alu_b = ALU_W'(batt_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
		alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
		alu_borrow = alu_diff[ALU_W];
	end

	// Duty calculation finish: saturation or last divider step
	always_comb begin
		fin_go   = 1'b0;
		fin_duty = DUTY_MAX;
		if (state_q == S_DCHK && (batt_q == '0 || !alu_borrow)) begin
			fin_go = 1'b1;
		end else if (state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) begin
			fin_go   = 1'b1;
			fin_duty = {qsh_q[DUTY_W-2:0], !alu_borrow};
		end
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ret_q          <= S_IDLE;
			last_q         <= 1'b0;
			pfire_q        <= 1'b0;
			cnt_q          <= '0;
			swing_low_q    <= SWING_LOW_RST;
			swing_full_q   <= SWING_FULL_RST;
			max_pulses_q   <= MAX_PULSES_RST;
			refresh_q      <= REFRESH_RST;
			duty_q         <= '0;
			pump_bit_q     <= 1'b0;
			swing_sw_q     <= 1'b0;
			pump_sw_q      <= 1'b0;
			pulse_q        <= '0;
			last_pump_q    <= '0;
			last_refresh_q <= '0;
			mode_changed_q <= 1'b1;
			swing_high_q   <= 1'b1;
			pump_level_q   <= PLVL_LOW;
			out_valid_q    <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_SWING_LOW:  swing_low_q  <= cfg_data[MV_W-1:0];
					REG_SWING_FULL: swing_full_q <= cfg_data[MV_W-1:0];
					REG_MAX_PULSES: max_pulses_q <= cfg_data[PULSE_W-1:0];
					REG_REFRESH:    refresh_q    <= cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end

			// output register drains
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= 1'b1;
						ret_q  <= S_IDLE;
						case (op)
							OP_TICK: state_q <= S_PSUB;
							OP_OPEN_SWING, OP_OPEN_BOTH: state_q <= S_PROD;
							OP_OPEN_PUMP: begin
								pump_bit_q  <= 1'b1;
								last_pump_q <= '0;
								pump_sw_q   <= 1'b1;
								state_q     <= S_EMIT;
							end
							OP_STOP_SWING: begin
								duty_q     <= '0;
								swing_sw_q <= 1'b0;
								state_q    <= S_EMIT;
							end
							OP_STOP_PUMP: begin
								pump_bit_q <= 1'b0;
								pump_sw_q  <= 1'b0;
								state_q    <= S_EMIT;
							end
							OP_STOP_BOTH: begin
								duty_q     <= '0;
								pump_bit_q <= 1'b0;
								swing_sw_q <= 1'b0;
								pump_sw_q  <= 1'b0;
								state_q    <= S_EMIT;
							end
							OP_MODE_SWING: begin
								mode_changed_q <= 1'b1;
								if (mode_value == SWING_LOW) begin
									swing_high_q <= 1'b0;
								end else if (mode_value == SWING_HIGH) begin
									swing_high_q <= 1'b1;
								end
							end
							OP_MODE_PUMP: begin
								if (mode_value == PLVL_MID || mode_value == PLVL_HIGH) begin
									pump_level_q <= mode_value;
								end else begin
									pump_level_q <= PLVL_LOW;
								end
							end
							default: ;
						endcase
					end
				end
				S_PSUB: state_q <= S_PCMP;
				S_PCMP: begin
					// elapsed > interval when interval - elapsed borrows
					pfire_q <= pump_sw_q && alu_borrow;
					state_q <= S_RSUB;
				end
				S_RSUB: state_q <= S_RCMP;
				S_RCMP: begin
					if (swing_sw_q && (alu_borrow || mode_changed_q)) begin
						mode_changed_q <= 1'b0;
						state_q        <= S_PROD;
					end else if (pfire_q) begin
						state_q <= S_PUPD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PROD: state_q <= S_DCHK;
				S_DCHK: begin
					cnt_q <= '0;
					if (!fin_go) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: cnt_q <= cnt_q + 1'b1;
				S_PUPD: begin
					if (pulse_nxt <= {1'b0, max_pulses_q}) begin
						pulse_q    <= pulse_nxt[PULSE_W-1:0];
						pump_bit_q <= 1'b1;
					end else begin
						pulse_q     <= '0;
						pump_bit_q  <= 1'b0;
						last_pump_q <= now_q;
					end
					last_q  <= 1'b1;
					ret_q   <= S_IDLE;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// duty refresh done: apply and queue the result
			if (fin_go) begin
				duty_q         <= fin_duty;
				last_refresh_q <= now_q;
				state_q        <= S_EMIT;
				if (op_q == OP_TICK) begin
					last_q <= !pfire_q;
					ret_q  <= pfire_q ? S_PUPD : S_IDLE;
				end else begin
					swing_sw_q <= 1'b1;
					last_q     <= 1'b1;
					ret_q      <= S_IDLE;
					if (op_q == OP_OPEN_BOTH) begin
						pump_bit_q  <= 1'b1;
						last_pump_q <= '0;
						pump_sw_q   <= 1'b1;
					end
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op;
			now_q  <= now_w;
			batt_q <= battery_mv;
		end
		if (state_q == S_PSUB) begin
			el_q       <= alu_diff[TIME_BITS-1:0];
			interval_q <= INTV_W'(pump_k400(pump_level_q)) * INTV_W'(max_pulses_q);
		end
		if (state_q == S_RSUB) begin
			el_q <= alu_diff[TIME_BITS-1:0];
		end
		if (state_q == S_PROD) begin
			num_q <= NUM_W'(swing_high_q ? swing_full_q : swing_low_q) * NUM_W'(PCT_SCALE);
		end
		if (state_q == S_DCHK) begin
			rem_q <= num_q[NUM_W-1:DUTY_W];
			qsh_q <= num_q[DUTY_W-1:0];
		end
		if (state_q == S_DIV) begin
			rem_q <= alu_borrow ? div_t[MV_W-1:0] : alu_diff[MV_W-1:0];
			qsh_q <= {qsh_q[DUTY_W-2:0], !alu_borrow};
		end
		if (state_q == S_EMIT && out_free) begin
			cmd_q      <= {pump_bit_q, duty_q};
			swing_on_q <= swing_sw_q;
			pump_on_q  <= pump_sw_q;
			last_out_q <= last_q;
		end
	end

	// Swing stopped always leaves a zero duty
	a_duty_off: assert property (@(posedge clk) disable iff (!arst_n)
		!swing_sw_q |-> duty_q == '0)
		else $error("duty nonzero with swing switch off");

	// Pump drive bit only with the pump switched on
	a_pump_bit: assert property (@(posedge clk) disable iff (!arst_n)
		pump_bit_q |-> pump_sw_q)
		else $error("pump bit set with pump switch off");

	// Divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < batt_q)
		else $error("divider remainder out of range");

	// A swing mode transaction marks a mode change
	a_mode_chg: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == OP_MODE_SWING |=> mode_changed_q)
		else $error("swing mode change not recorded");

endmodule

// ===== dv/tb_pump_and_swing_motor_drive_top.sv =====
`timescale 1ns / 1ps

module tb_pump_and_swing_motor_drive_top;
	import psmd_pkg::*;

	// Codes with no name in the package
	localparam logic [OP_W-1:0]   OP_FIRST_UNUSED = OP_MODE_PUMP + 1'b1;
	localparam logic [OP_W-1:0]   OP_LAST_UNUSED  = '1;
	localparam logic [MODE_W-1:0] SWING_KEEP_A    = 2'd2;
	localparam logic [MODE_W-1:0] SWING_KEEP_B    = 2'd3;
	localparam logic [MODE_W-1:0] PUMP_ALIAS_LOW  = 2'd3;

	// Idle time after the last result before a register write
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [7:0] cmd;
		logic       swing_on;
		logic       pump_on;
		logic       last;
	} drive_result_t;

	// Drive state tracker and the queue of drive bytes it expects
	class drive_scoreboard;
		logic [MV_W-1:0]     low_mv, full_mv;
		logic [PULSE_W-1:0]  max_pulses;
		logic [PERIOD_W-1:0] refresh_ms;
		logic [DUTY_W-1:0]   duty;
		logic                pump_bit, swing_sw, pump_sw, mode_dirty, swing_hi;
		logic [PULSE_W-1:0]  pulses;
		logic [NOW_W-1:0]    pump_stamp, refresh_stamp;
		logic [MODE_W-1:0]   pump_lvl;
		drive_result_t       expected_q[$];
		int                  errors;

		function new();
			low_mv        = SWING_LOW_RST;
			full_mv       = SWING_FULL_RST;
			max_pulses    = MAX_PULSES_RST;
			refresh_ms    = REFRESH_RST;
			duty          = '0;
			pump_bit      = 1'b0;
			swing_sw      = 1'b0;
			pump_sw       = 1'b0;
			pulses        = '0;
			pump_stamp    = '0;
			refresh_stamp = '0;
			mode_dirty    = 1'b1;
			swing_hi      = 1'b1;
			pump_lvl      = PLVL_LOW;
			errors        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SWING_LOW:  low_mv     = data[MV_W-1:0];
				REG_SWING_FULL: full_mv    = data[MV_W-1:0];
				REG_MAX_PULSES: max_pulses = data[PULSE_W-1:0];
				REG_REFRESH:    refresh_ms = data[PERIOD_W-1:0];
				default: ;
			endcase
		endfunction

		// Duty = mode voltage * 100 / battery, saturated
		function void refresh_duty(logic [NOW_W-1:0] now, logic [MV_W-1:0] batt);
			logic [31:0] volts, q;
			volts = swing_hi ? {16'd0, full_mv} : {16'd0, low_mv};
			q = (batt == '0) ? 32'd127 : (volts * 32'd100) / {16'd0, batt};
			if (q > 32'd127)
				q = 32'd127;
			duty = q[DUTY_W-1:0];
			refresh_stamp = now;
		endfunction

		// Work out the drive bytes caused by one accepted transaction
		function void note_item(logic [OP_W-1:0] code, logic [NOW_W-1:0] now,
				logic [MV_W-1:0] batt, logic [MODE_W-1:0] mode);
			logic [7:0]       cmd[2];
			int               n;
			logic [NOW_W-1:0] elapsed;
			logic [31:0]      per_pulse, interval;
			logic [PULSE_W:0] next_count;
			drive_result_t    r;
			n = 0;
			case (code)
				OP_TICK: begin
					elapsed = now - refresh_stamp;
					if (swing_sw && (elapsed > {12'd0, refresh_ms} || mode_dirty)) begin
						mode_dirty = 1'b0;
						refresh_duty(now, batt);
						cmd[n] = {pump_bit, duty};
						n++;
					end
					case (pump_lvl)
						PLVL_HIGH: per_pulse = 32'd3200;
						PLVL_MID:  per_pulse = 32'd4800;
						default:   per_pulse = 32'd6000;
					endcase
					interval = per_pulse * {24'd0, max_pulses};
					elapsed = now - pump_stamp;
					if (pump_sw && elapsed > interval) begin
						// extra bit keeps a 255-pulse burst from wrapping
						next_count = {1'b0, pulses} + 1'b1;
						if (next_count <= {1'b0, max_pulses}) begin
							pulses = next_count[PULSE_W-1:0];
							pump_bit = 1'b1;
						end else begin
							pump_bit = 1'b0;
							pulses = '0;
							pump_stamp = now;
						end
						cmd[n] = {pump_bit, duty};
						n++;
					end
				end
				OP_OPEN_SWING: begin
					refresh_duty(now, batt);
					swing_sw = 1'b1;
					cmd[n] = {pump_bit, duty};
					n++;
				end
				OP_OPEN_PUMP: begin
					pump_bit = 1'b1;
					pump_stamp = '0;
					pump_sw = 1'b1;
					cmd[n] = {pump_bit, duty};
					n++;
				end
				OP_OPEN_BOTH: begin
					refresh_duty(now, batt);
					pump_bit = 1'b1;
					pump_stamp = '0;
					swing_sw = 1'b1;
					pump_sw = 1'b1;
					cmd[n] = {pump_bit, duty};
					n++;
				end
				OP_STOP_SWING: begin
					duty = '0;
					swing_sw = 1'b0;
					cmd[n] = {pump_bit, 7'd0};
					n++;
				end
				OP_STOP_PUMP: begin
					pump_bit = 1'b0;
					pump_sw = 1'b0;
					cmd[n] = {1'b0, duty};
					n++;
				end
				OP_STOP_BOTH: begin
					duty = '0;
					pump_bit = 1'b0;
					swing_sw = 1'b0;
					pump_sw = 1'b0;
					cmd[n] = 8'd0;
					n++;
				end
				OP_MODE_SWING: begin
					// unnamed swing modes keep the voltage but still force a refresh
					mode_dirty = 1'b1;
					if (mode == SWING_LOW)
						swing_hi = 1'b0;
					else if (mode == SWING_HIGH)
						swing_hi = 1'b1;
				end
				OP_MODE_PUMP: pump_lvl = (mode <= PLVL_HIGH) ? mode : PLVL_LOW;
				default: ;
			endcase
			for (int i = 0; i < n; i++) begin
				r.cmd = cmd[i];
				r.swing_on = swing_sw;
				r.pump_on = pump_sw;
				r.last = (i == n - 1);
				expected_q.push_back(r);
			end
		endfunction

		function void report(string field, logic [7:0] exp_v, logic [7:0] act_v);
			errors++;
			$display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
		endfunction

		// Compare one accepted drive byte with the oldest expectation
		function void check_result(logic [7:0] cmd, logic sw, logic pu, logic lst);
			drive_result_t exp_r;
			if (expected_q.size() == 0) begin
				report("unexpected cmd_byte", 8'h00, cmd);
				return;
			end
			exp_r = expected_q.pop_front();
			if (exp_r.cmd !== cmd)
				report("cmd_byte", exp_r.cmd, cmd);
			if (exp_r.swing_on !== sw)
				report("swing_on", {7'd0, exp_r.swing_on}, {7'd0, sw});
			if (exp_r.pump_on !== pu)
				report("pump_on", {7'd0, exp_r.pump_on}, {7'd0, pu});
			if (exp_r.last !== lst)
				report("last", {7'd0, exp_r.last}, {7'd0, lst});
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      op;
	logic [NOW_W-1:0]     now_ms;
	logic [MV_W-1:0]      battery_mv;
	logic [MODE_W-1:0]    mode_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           cmd_byte;
	logic                 swing_on;
	logic                 pump_on;
	logic                 last;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	drive_scoreboard  sb = new();
	logic [NOW_W-1:0] clock_ms;
	int               phase_no = -1;
	bit               tx_idle = 1'b1;
	bit               rx_idle = 1'b1;

	pump_and_swing_motor_drive_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.now_ms     (now_ms),
		.battery_mv (battery_mv),
		.mode_value (mode_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd_byte   (cmd_byte),
		.swing_on   (swing_on),
		.pump_on    (pump_on),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Offer one transaction, after a random gap while tx_idle is set, hold it until accepted
	task automatic send_item(logic [OP_W-1:0] code, logic [NOW_W-1:0] stamp,
			logic [MV_W-1:0] batt, logic [MODE_W-1:0] mode);
		int gap, r;
		gap = 0;
		if (tx_idle) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(10, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= code;
		now_ms <= stamp;
		battery_mv <= batt;
		mode_value <= mode;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_item(code, stamp, batt, mode);
	endtask

	// Drain all expected bytes and let a silent tick finish
	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic [MV_W-1:0] low, logic [MV_W-1:0] full,
			logic [PULSE_W-1:0] pulses, logic [PERIOD_W-1:0] refresh);
		logic [CFG_W-1:0] vals[4];
		vals[REG_SWING_LOW]  = CFG_W'(low);
		vals[REG_SWING_FULL] = CFG_W'(full);
		vals[REG_MAX_PULSES] = CFG_W'(pulses);
		vals[REG_REFRESH]    = CFG_W'(refresh);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [OP_W-1:0] pick_op(bit allow_stop);
		int r;
		r = $urandom_range(0, 99);
		if (!allow_stop && r < 90)
			return OP_TICK;
		if (r < 55)
			return OP_TICK;
		if (r < 62)
			return OP_OPEN_SWING;
		if (r < 67)
			return OP_OPEN_PUMP;
		if (r < 71)
			return OP_OPEN_BOTH;
		if (r < 75)
			return allow_stop ? OP_STOP_SWING : OP_TICK;
		if (r < 78)
			return allow_stop ? OP_STOP_PUMP : OP_TICK;
		if (r < 80)
			return allow_stop ? OP_STOP_BOTH : OP_TICK;
		if (r < 88)
			return OP_MODE_SWING;
		if (r < 96)
			return OP_MODE_PUMP;
		return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
	endfunction

	// Random transactions on an advancing, sometimes jumping, time base
	task automatic run_random(int count, int step_max, bit allow_stop);
		int               done, r;
		logic [OP_W-1:0]  code;
		logic [MV_W-1:0]  batt;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				clock_ms += $urandom_range(0, step_max);
			else if (r < 95)
				clock_ms += $urandom_range(0, 200000);
			else if (r < 99)
				clock_ms += $urandom_range(0, 2000000);
			else
				clock_ms = $urandom;
			code = pick_op(allow_stop);
			r = $urandom_range(0, 99);
			if (r < 5)
				batt = '0;
			else if (r < 80)
				batt = MV_W'($urandom_range(6000, 16000));
			else
				batt = MV_W'($urandom);
			send_item(code, clock_ms, batt, MODE_W'($urandom_range(0, 3)));
			if (code <= OP_MODE_PUMP)
				done++;
		end
		in_valid <= 1'b0;
	endtask

	// Receiver: check accepted bytes, stall at random while rx_idle, one long hold-off
	initial begin
		int stall_left, hold_left, r;
		bit pressed;
		stall_left = 0;
		hold_left = 0;
		pressed = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(cmd_byte, swing_on, pump_on, last);
			if (phase_no == 1 && !pressed) begin
				pressed = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!rx_idle) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(20, 60);
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_TICK;
		now_ms <= '0;
		battery_mv <= '0;
		mode_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SWING_LOW;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, ignored codes, every swing mode, pump modes, saturation, wrap, burst end
		phase_no = 0;
		send_item(OP_TICK, 32'd0, 16'd12000, SWING_LOW);
		send_item(OP_FIRST_UNUSED, 32'hffff_ffff, 16'hffff, SWING_KEEP_B);
		send_item(OP_LAST_UNUSED, 32'd0, 16'd0, SWING_LOW);
		send_item(OP_MODE_SWING, 32'd10, 16'd12000, SWING_KEEP_A);
		send_item(OP_MODE_SWING, 32'd10, 16'd12000, SWING_LOW);
		send_item(OP_MODE_SWING, 32'd10, 16'd12000, SWING_KEEP_B);
		send_item(OP_MODE_SWING, 32'd10, 16'd12000, SWING_HIGH);
		send_item(OP_MODE_PUMP, 32'd20, 16'd12000, PUMP_ALIAS_LOW);
		send_item(OP_MODE_PUMP, 32'd20, 16'd12000, PLVL_HIGH);
		send_item(OP_MODE_PUMP, 32'd20, 16'd12000, PLVL_LOW);
		send_item(OP_OPEN_SWING, 32'd100, 16'd0, SWING_LOW);
		send_item(OP_OPEN_SWING, 32'd200, 16'd1000, SWING_LOW);
		send_item(OP_OPEN_SWING, 32'd200, 16'hffff, SWING_LOW);
		send_item(OP_OPEN_PUMP, 32'd300, 16'd12000, SWING_LOW);
		send_item(OP_TICK, 32'hffff_ffff, 16'd12000, SWING_LOW);
		send_item(OP_MODE_SWING, 32'd0, 16'd9000, SWING_LOW);
		send_item(OP_TICK, 32'd5, 16'd9000, SWING_LOW);
		for (int i = 0; i < 5; i++)
			send_item(OP_TICK, 32'd40000 + i, 16'd9000, SWING_LOW);
		send_item(OP_STOP_SWING, 32'd40010, 16'd9000, SWING_LOW);
		send_item(OP_STOP_PUMP, 32'd40020, 16'd9000, SWING_LOW);
		send_item(OP_OPEN_BOTH, 32'd40030, 16'd12345, SWING_LOW);
		send_item(OP_STOP_BOTH, 32'd40040, 16'd12345, SWING_LOW);
		in_valid <= 1'b0;

		// Phase 0: reset configuration
		clock_ms = 32'd50000;
		run_random(130, 12000, 1'b1);
		settle();

		// Phase 1: low extremes, receiver backs up once
		write_config(16'd0, 16'hffff, 8'd1, 20'd1);
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		phase_no = 1;
		run_random(130, 3000, 1'b1);
		settle();

		// Phase 2: high extremes, long bursts to reach the 255-pulse end
		write_config(16'hffff, 16'd0, 8'd255, 20'd600000);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		phase_no = 2;
		clock_ms = $urandom_range(32'h1000_0000, 32'hf000_0000);
		run_random(300, 20000, 1'b0);
		settle();

		// Phase 3: random configuration
		write_config(MV_W'($urandom), MV_W'($urandom), PULSE_W'($urandom_range(1, 12)),
			PERIOD_W'($urandom_range(1, 600000)));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		phase_no = 3;
		run_random(90, $urandom_range(1000, 40000), 1'b1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
